### design/knnv_pkg.sv
// knnv_pkg: shared widths, constants, types and the byte vote function
// for the three-nearest-neighbor label vote block. No dependencies.
`timescale 1ns / 1ps

package knnv_pkg;

  // default configuration
  localparam int unsigned MaxRecords   = 1024;
  localparam int unsigned FeatureCount = 8;
  localparam int unsigned LabelChars   = 8;

  // fixed widths of the item fields
  localparam int unsigned MaxFeatures = 8;
  localparam int unsigned SlotCount   = 3;
  localparam int unsigned ScoreW      = 16;
  localparam int unsigned SqW         = 32;
  localparam int unsigned PairW       = 33;
  localparam int unsigned DistW       = 35;
  localparam int unsigned LabelW      = 64;
  localparam int unsigned CharW       = 8;
  localparam int unsigned OutIdxW     = 10;
  localparam int unsigned CountW      = 2;

  localparam logic [CharW-1:0]  NoMajority = 8'h78;
  localparam logic [DistW-1:0]  EmptyDist  = '1;
  localparam logic [CountW-1:0] CountFull  = 2'd3;
  localparam logic [CountW-1:0] CountTwo   = 2'd2;
  localparam logic [CountW-1:0] CountOne   = 2'd1;

  // one candidate record entering the ranking stage
  typedef struct packed {
    logic [DistW-1:0]   sqdist;
    logic [LabelW-1:0]  label;
    logic [OutIdxW-1:0] index;
    logic               consider;
    logic               last;
  } cand_t;

  // kept neighbors, slot 0 nearest
  typedef struct packed {
    logic [SlotCount-1:0][LabelW-1:0]  label;
    logic [SlotCount-1:0][OutIdxW-1:0] index;
    logic [CountW-1:0]                 count;
  } slots_t;

  // one result item
  typedef struct packed {
    logic [LabelW-1:0]  voted_label;
    logic [OutIdxW-1:0] nearest_index;
    logic [OutIdxW-1:0] second_index;
    logic [OutIdxW-1:0] third_index;
    logic [CountW-1:0]  neighbors_found;
  } result_t;

  // majority of one character position over the filled slots
  function automatic logic [CharW-1:0] vote_byte(input logic [CharW-1:0]  b0,
                                                 input logic [CharW-1:0]  b1,
                                                 input logic [CharW-1:0]  b2,
                                                 input logic [CountW-1:0] count);
    logic [CharW-1:0] v;
    v = NoMajority;
    if (count == CountFull) begin
      if (b0 == b1 || b0 == b2) v = b0;
      else if (b1 == b2)        v = b1;
      else                      v = NoMajority;
    end else if (count == CountTwo) begin
      v = (b0 == b1) ? b0 : NoMajority;
    end else if (count == CountOne) begin
      v = b0;
    end
    return v;
  endfunction

endpackage

### design/knnv_lane.sv
// knnv_lane: one feature lane, absolute difference to the query score
// squared and registered. Depends on knnv_pkg.
`timescale 1ns / 1ps

module knnv_lane (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [knnv_pkg::ScoreW-1:0] score_i,
  input  logic [knnv_pkg::ScoreW-1:0] query_i,
  output logic [knnv_pkg::SqW-1:0]    sq_o
);
  import knnv_pkg::*;

  logic [ScoreW-1:0] diff;
  logic [SqW-1:0]    sq_d, sq_q;

  // absolute difference and square
  assign diff = (score_i >= query_i) ? (score_i - query_i) : (query_i - score_i);
  assign sq_d = SqW'(diff) * SqW'(diff);

  // stage register
  always_ff @(posedge clk_i) begin
    if (en_i) sq_q <= sq_d;
  end

  assign sq_o = sq_q;

endmodule

### design/knnv_rank.sv
// knnv_rank: keeps the three nearest records and inserts one candidate
// per cycle while fire_i is high; hands out the kept slots after a run's
// last record. Depends on knnv_pkg.
`timescale 1ns / 1ps

module knnv_rank (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  knnv_pkg::cand_t     cand_i,
  output knnv_pkg::slots_t    post_o
);
  import knnv_pkg::*;

  logic [SlotCount-1:0][DistW-1:0]   dist_q, dist_d, dist_p;
  logic [SlotCount-1:0][LabelW-1:0]  label_q, label_d, label_p;
  logic [SlotCount-1:0][OutIdxW-1:0] index_q, index_d, index_p;
  logic [CountW-1:0]                 count_q, count_d, count_p;
  logic                              ins0, ins1, ins2;

  // where the candidate lands; slots stay sorted so ins0 implies ins1 implies ins2
  assign ins0 = cand_i.consider && (cand_i.sqdist < dist_q[0]);
  assign ins1 = cand_i.consider && (cand_i.sqdist < dist_q[1]);
  assign ins2 = cand_i.consider && (cand_i.sqdist < dist_q[2]);

  // shift and insert
  always_comb begin
    dist_p  = dist_q;
    label_p = label_q;
    index_p = index_q;
    count_p = count_q;
    if (ins0) begin
      dist_p[0] = cand_i.sqdist;  label_p[0] = cand_i.label;  index_p[0] = cand_i.index;
    end
    if (ins0) begin
      dist_p[1] = dist_q[0];      label_p[1] = label_q[0];    index_p[1] = index_q[0];
    end else if (ins1) begin
      dist_p[1] = cand_i.sqdist;  label_p[1] = cand_i.label;  index_p[1] = cand_i.index;
    end
    if (ins1) begin
      dist_p[2] = dist_q[1];      label_p[2] = label_q[1];    index_p[2] = index_q[1];
    end else if (ins2) begin
      dist_p[2] = cand_i.sqdist;  label_p[2] = cand_i.label;  index_p[2] = cand_i.index;
    end
    if (ins2 && count_q != CountFull) count_p = count_q + CountOne;
  end

  // next state: clear after the last record of a run
  always_comb begin
    dist_d  = dist_q;
    label_d = label_q;
    index_d = index_q;
    count_d = count_q;
    if (fire_i) begin
      if (cand_i.last) begin
        dist_d  = {SlotCount{EmptyDist}};
        label_d = '0;
        index_d = '0;
        count_d = '0;
      end else begin
        dist_d  = dist_p;
        label_d = label_p;
        index_d = index_p;
        count_d = count_p;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q  <= {SlotCount{EmptyDist}};
      label_q <= '0;
      index_q <= '0;
      count_q <= '0;
    end else begin
      dist_q  <= dist_d;
      label_q <= label_d;
      index_q <= index_d;
      count_q <= count_d;
    end
  end

  assign post_o.label = label_p;
  assign post_o.index = index_p;
  assign post_o.count = count_p;

endmodule

### design/knnv_vote.sv
// knnv_vote: holds the kept slots of a finished run and forms the
// per-character majority label. Depends on knnv_pkg.
`timescale 1ns / 1ps

module knnv_vote #(
  parameter int unsigned LABEL_CHARS = knnv_pkg::LabelChars
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              take_i,
  input  knnv_pkg::slots_t  snap_i,
  output logic              valid_o,
  output knnv_pkg::result_t result_o
);
  import knnv_pkg::*;

  slots_t             snap_q;
  logic               valid_q, valid_d;
  logic [LabelW-1:0]  voted;

  // snapshot register
  always_ff @(posedge clk_i) begin
    if (load_i) snap_q <= snap_i;
  end

  assign valid_d = load_i ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_d;
  end

  // per-character vote, bytes above the label length read zero
  always_comb begin
    voted = '0;
    for (int c = 0; c < LABEL_CHARS; c++) begin
      voted[c*CharW +: CharW] = vote_byte(snap_q.label[0][c*CharW +: CharW],
                                          snap_q.label[1][c*CharW +: CharW],
                                          snap_q.label[2][c*CharW +: CharW],
                                          snap_q.count);
    end
  end

  assign valid_o                  = valid_q;
  assign result_o.voted_label     = voted;
  assign result_o.nearest_index   = snap_q.index[0];
  assign result_o.second_index    = snap_q.index[1];
  assign result_o.third_index     = snap_q.index[2];
  assign result_o.neighbors_found = snap_q.count;

endmodule

### design/knn_top3_label_vote_unit.sv
// knn_top3_label_vote_unit: top level of the three-nearest-neighbor label
// vote block. Depends on knnv_pkg, knnv_lane, knnv_rank and knnv_vote.
//
// Usage: records stream in on the in channel (valid/ready), one item per
// record. The first record of a run is the query; every later record is
// scored by squared Euclidean distance to it and the three nearest are kept
// (earlier record wins a tie). The record marked final_record closes the run
// and yields one result item on the out channel: a per-character majority
// label ('x' where there is none), the three neighbor indices and the count
// of filled slots. Other records yield no result.
// Throughput: one record per cycle, set by the top-three insertion loop,
// unless out-channel back-pressure stalls the input; squares, adds and
// the vote are pipelined around that loop. A final record's result passes
// the lane, pair sum, distance, snapshot and output registers in turn.
// Reset: all pipeline valids clear, the neighbor slots empty and the record
// counter returns to zero, so the next record is a query.
// Stall: a result waits in the output register and a second one in the vote
// snapshot while records without a result keep flowing; in_ready_o drops
// only once a third final record sits in the distance stage behind them and
// the two stages before it are occupied.
`timescale 1ns / 1ps

module knn_top3_label_vote_unit #(
  parameter int unsigned MAX_RECORDS   = knnv_pkg::MaxRecords,
  parameter int unsigned FEATURE_COUNT = knnv_pkg::FeatureCount,
  parameter int unsigned LABEL_CHARS   = knnv_pkg::LabelChars
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [knnv_pkg::ScoreW-1:0]  score_ne_i,
  input  logic [knnv_pkg::ScoreW-1:0]  score_ni_i,
  input  logic [knnv_pkg::ScoreW-1:0]  score_te_i,
  input  logic [knnv_pkg::ScoreW-1:0]  score_ti_i,
  input  logic [knnv_pkg::ScoreW-1:0]  score_se_i,
  input  logic [knnv_pkg::ScoreW-1:0]  score_si_i,
  input  logic [knnv_pkg::ScoreW-1:0]  score_fe_i,
  input  logic [knnv_pkg::ScoreW-1:0]  score_fi_i,
  input  logic [knnv_pkg::LabelW-1:0]  label_bytes_i,
  input  logic                         final_record_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [knnv_pkg::LabelW-1:0]  voted_label_o,
  output logic [knnv_pkg::OutIdxW-1:0] nearest_index_o,
  output logic [knnv_pkg::OutIdxW-1:0] second_index_o,
  output logic [knnv_pkg::OutIdxW-1:0] third_index_o,
  output logic [knnv_pkg::CountW-1:0]  neighbors_found_o
);
  import knnv_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_RECORDS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_RECORDS);

  // handshake and pipeline control
  logic in_fire, en1, en2, en3, adv3, fire4, v4;
  logic v1_q, v2_q, v3_q;

  // record counter and query
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [31:0]       cnt_ext;
  logic [ScoreW-1:0] query_q [FEATURE_COUNT];
  logic [ScoreW-1:0] score_in [MaxFeatures];

  // stage payloads
  logic [MaxFeatures-1:0][SqW-1:0] sq1;
  logic [3:0][PairW-1:0]           pair2_q;
  logic [DistW-1:0]                dist3_q;
  logic [LabelW-1:0]               label1_q, label2_q, label3_q;
  logic [OutIdxW-1:0]              idx1_q, idx2_q, idx3_q;
  logic                            cons1_q, cons2_q, cons3_q;
  logic                            last1_q, last2_q, last3_q;

  cand_t   cand3;
  slots_t  post;
  result_t res4, out_q;
  logic    out_valid_q;

  assign score_in[0] = score_ne_i;
  assign score_in[1] = score_ni_i;
  assign score_in[2] = score_te_i;
  assign score_in[3] = score_ti_i;
  assign score_in[4] = score_se_i;
  assign score_in[5] = score_si_i;
  assign score_in[6] = score_fe_i;
  assign score_in[7] = score_fi_i;

  // elastic pipeline: a stage loads when empty or when it moves on
  assign fire4      = v4 && (!out_valid_q || out_ready_i);
  assign adv3       = v3_q && (!last3_q || !v4 || fire4);
  assign en3        = !v3_q || adv3;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign in_fire    = in_valid_i && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_fire;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // record counter, saturates at the record limit, clears after a run
  always_comb begin
    cnt_d = cnt_q;
    if (in_fire) begin
      if (final_record_i)      cnt_d = '0;
      else if (cnt_q < CntMax) cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_d;
  end

  assign cnt_ext = 32'(cnt_q);

  // query capture on the first record of a run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int f = 0; f < FEATURE_COUNT; f++) query_q[f] <= '0;
    end else if (in_fire && cnt_q == '0) begin
      for (int f = 0; f < FEATURE_COUNT; f++) query_q[f] <= score_in[f];
    end
  end

  // feature lanes
  for (genvar f = 0; f < MaxFeatures; f++) begin : g_lane
    if (f < FEATURE_COUNT) begin : g_used
      knnv_lane u_lane (
        .clk_i   (clk_i),
        .en_i    (en1),
        .score_i (score_in[f]),
        .query_i (query_q[f]),
        .sq_o    (sq1[f])
      );
    end else begin : g_unused
      assign sq1[f] = '0;
    end
  end

  // stage 1 side payload
  always_ff @(posedge clk_i) begin
    if (en1) begin
      label1_q <= label_bytes_i;
      idx1_q   <= cnt_ext[OutIdxW-1:0];
      cons1_q  <= (cnt_q != '0) && (cnt_q < CntMax);
      last1_q  <= final_record_i;
    end
  end

  // stage 2: pair sums of the lane squares
  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int p = 0; p < 4; p++) begin
        pair2_q[p] <= PairW'(sq1[2*p]) + PairW'(sq1[2*p+1]);
      end
      label2_q <= label1_q;
      idx2_q   <= idx1_q;
      cons2_q  <= cons1_q;
      last2_q  <= last1_q;
    end
  end

  // stage 3: full squared distance
  always_ff @(posedge clk_i) begin
    if (en3) begin
      dist3_q  <= (DistW'(pair2_q[0]) + DistW'(pair2_q[1]))
                + (DistW'(pair2_q[2]) + DistW'(pair2_q[3]));
      label3_q <= label2_q;
      idx3_q   <= idx2_q;
      cons3_q  <= cons2_q;
      last3_q  <= last2_q;
    end
  end

  assign cand3.sqdist   = dist3_q;
  assign cand3.label    = label3_q;
  assign cand3.index    = idx3_q;
  assign cand3.consider = cons3_q;
  assign cand3.last     = last3_q;

  // top-three insertion
  knnv_rank u_rank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (adv3),
    .cand_i (cand3),
    .post_o (post)
  );

  // snapshot and vote
  knnv_vote #(
    .LABEL_CHARS (LABEL_CHARS)
  ) u_vote (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (adv3 && last3_q),
    .take_i   (fire4),
    .snap_i   (post),
    .valid_o  (v4),
    .result_o (res4)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          out_valid_q <= 1'b0;
    else if (fire4)       out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (fire4) out_q <= res4;
  end

  assign out_valid_o       = out_valid_q;
  assign voted_label_o     = out_q.voted_label;
  assign nearest_index_o   = out_q.nearest_index;
  assign second_index_o    = out_q.second_index;
  assign third_index_o     = out_q.third_index;
  assign neighbors_found_o = out_q.neighbors_found;

`ifndef SYNTH
  // input backpressure only when every stage is occupied
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && v4))
    else $error("in_ready_o low with an empty pipeline stage");

  // an empty third slot reports index zero
  a_empty_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && neighbors_found_o != CountFull) |-> (third_index_o == '0))
    else $error("empty neighbor slot with nonzero index");

  // a vote taken from the snapshot shows up on the output
  a_vote_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire4 |=> out_valid_o)
    else $error("vote result lost on the way to the output");
`endif

endmodule
